// ===== hw/rtl/fscp_pkg.sv =====
// ----------------------------------------------------------------------------
// fscp_pkg: shared types, constants and helpers for the four-star pose block
// Holds the CORDIC angle table, fixed-point constants and small helpers.
// ----------------------------------------------------------------------------
package fscp_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int CFG_BITS       = 14;
    localparam int POS_BITS       = 17;
    localparam int HEAD_BITS      = 16;
    localparam int ANG_BITS       = 20;    // radians Q16, covers +/- 2*pi
    localparam int CORDIC_STEPS   = 16;
    localparam int CS_BITS        = 16;    // sin/cos Q14 with headroom

    localparam logic signed [ANG_BITS-1:0] PI_Q16      = 20'sd205888;
    localparam logic signed [ANG_BITS-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [CS_BITS-1:0]  GAIN_Q14    = 16'sd9949;

    localparam logic signed [47:0] WORLD_X_Q4 = 48'sd8184;
    localparam logic signed [47:0] WORLD_Y_Q4 = 48'sd6136;
    localparam logic signed [47:0] MIRROR_Q4  = 48'sd16352;
    localparam logic signed [47:0] POS_MIN    = -48'sd65536;
    localparam logic signed [47:0] POS_MAX    = 48'sd65535;
    localparam logic signed [47:0] HEAD_MIN   = -48'sd6434;
    localparam logic signed [47:0] HEAD_MAX   = 48'sd19302;

    typedef enum logic [0:0] {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } cfg_idx_t;

    function automatic logic signed [ANG_BITS-1:0] atan_q16(input int unsigned i);
        logic signed [ANG_BITS-1:0] r;
        r = '0;
        unique case (i)
            0:  r = 20'sd51472;
            1:  r = 20'sd30386;
            2:  r = 20'sd16055;
            3:  r = 20'sd8150;
            4:  r = 20'sd4091;
            5:  r = 20'sd2047;
            6:  r = 20'sd1024;
            7:  r = 20'sd512;
            8:  r = 20'sd256;
            9:  r = 20'sd128;
            10: r = 20'sd64;
            11: r = 20'sd32;
            12: r = 20'sd16;
            13: r = 20'sd8;
            14: r = 20'sd4;
            15: r = 20'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_a(input logic [2:0] p);
        logic [1:0] r;
        r = 2'd0;
        unique case (p)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            3'd5:             r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] p);
        logic [1:0] r;
        r = 2'd1;
        unique case (p)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd2;
            3'd2, 3'd4, 3'd5: r = 2'd3;
            default:    r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [47:0] v,
                                                   input logic signed [47:0] lo,
                                                   input logic signed [47:0] hi);
        logic signed [47:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// ===== hw/rtl/four_star_constellation_pose_top.sv =====
// ----------------------------------------------------------------------------
// four_star_constellation_pose_top: camera pose from four blob coordinates
// Pair distances in six lanes, merge to north/south stars, CORDIC atan2,
// CORDIC sin/cos, pipelined square root, then position and saturation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | valid / stall  | star0_x .. star3_y
//  out     | output    | valid / stall  | found, pos_x, pos_y, heading
//  cfg     | input     | valid / ready  | index, data (center_x_q4, center_y_q4)
//
// Fully pipelined: one transaction per cycle while the output is not stalled;
// stages are distance lanes, merge, 16+16 CORDIC steps two per stage, sqrt,
// multiply and sum. The whole pipeline advances only when the output register
// is free, so a stall at the output holds every stage. Reset clears valid bits
// and restores the center registers; cfg is always ready.
module four_star_constellation_pose_top #(
    parameter int COORD_BITS = fscp_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [COORD_BITS-1:0]              star0_x,
    input  logic [COORD_BITS-1:0]              star0_y,
    input  logic [COORD_BITS-1:0]              star1_x,
    input  logic [COORD_BITS-1:0]              star1_y,
    input  logic [COORD_BITS-1:0]              star2_x,
    input  logic [COORD_BITS-1:0]              star2_y,
    input  logic [COORD_BITS-1:0]              star3_x,
    input  logic [COORD_BITS-1:0]              star3_y,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic signed [fscp_pkg::POS_BITS-1:0]  pos_x,
    output logic signed [fscp_pkg::POS_BITS-1:0]  pos_y,
    output logic signed [fscp_pkg::HEAD_BITS-1:0] heading,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [fscp_pkg::CFG_BITS-1:0]      cfg_data
);
    import fscp_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DB    = 2*CB + 2;          // squared distance bits
    localparam int VW    = CB + 8 + 4;        // vectoring datapath width
    localparam int RW    = CS_BITS + 2;       // rotation datapath width
    localparam int UW    = CB + 7;            // center offset width
    localparam int SQ_IN = DB + 6;            // 64*dmax
    localparam int SQ_STEPS = (SQ_IN + 1) / 2;
    localparam int SQ_W  = SQ_STEPS;          // root width
    localparam int VSTG  = CORDIC_STEPS / 2;  // two CORDIC steps per stage
    // stages: 0 dist, 1 merge, 2 prep, 3..3+VSTG-1 vect, then rotation
    localparam int S_ROT0 = 3 + VSTG;
    localparam int S_MUL  = S_ROT0 + VSTG + 1;
    localparam int PIPE_LEN = S_MUL + 3;
    localparam int SQ_N   = S_MUL - 3;
    localparam int SQ_PER = (SQ_STEPS + SQ_N - 1) / SQ_N;

    logic adv;
    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign cfg_ready = 1'b1;

    // configuration
    logic [CFG_BITS-1:0] cx_reg, cy_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= 14'd8184;
            cy_reg <= 14'd6136;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: cx_reg <= cfg_data;
                CFG_CENTER_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid pipeline
    logic [PIPE_LEN-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[PIPE_LEN-2:0], in_valid};
    end
    assign out_valid = v_reg[PIPE_LEN-1];

    // stage 0: lanes
    logic [CB-1:0] sx [4];
    logic [CB-1:0] sy [4];
    assign sx[0] = star0_x; assign sy[0] = star0_y;
    assign sx[1] = star1_x; assign sy[1] = star1_y;
    assign sx[2] = star2_x; assign sy[2] = star2_y;
    assign sx[3] = star3_x; assign sy[3] = star3_y;

    logic [DB-1:0] d [6];
    for (genvar p = 0; p < 6; p++)
    begin : g_lane
        fscp_dist_lane #(.COORD_BITS(CB)) u_lane (
            .clk (clk), .en (adv),
            .ax (sx[pair_a(3'(p))]), .ay (sy[pair_a(3'(p))]),
            .bx (sx[pair_b(3'(p))]), .by (sy[pair_b(3'(p))]),
            .dsq (d[p])
        );
    end

    logic [CB-1:0] x1_reg [4];
    logic [CB-1:0] y1_reg [4];
    logic          miss1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x1_reg[i] <= sx[i];
                y1_reg[i] <= sy[i];
            end
            miss1_reg <= (&sy[0]) | (&sy[1]) | (&sy[2]) | (&sy[3]);
        end
    end

    // stage 1: merge lanes into north/south
    logic [2:0]    imax, imin;
    logic [DB-1:0] dmx, dmn;
    logic [1:0]    north, south;
    logic          shared;
    logic [1:0]    mx0, mx1, mn0, mn1;
    always_comb
    begin
        imax = 3'd0; imin = 3'd0; dmx = d[0]; dmn = d[0];
        for (int p = 1; p < 6; p++)
        begin
            if (d[p] >= dmx)
            begin
                dmx = d[p];
                imax = 3'(p);
            end
            if (d[p] <= dmn)
            begin
                dmn = d[p];
                imin = 3'(p);
            end
        end
        mx0 = pair_a(imax); mx1 = pair_b(imax);
        mn0 = pair_a(imin); mn1 = pair_b(imin);
        shared = 1'b0; north = 2'd0;
        if (mx0 == mn0)
        begin
            north = mx0;
            shared = 1'b1;
        end
        if (mx0 == mn1)
        begin
            north = mx0;
            shared = 1'b1;
        end
        if (mx1 == mn0)
        begin
            north = mx1;
            shared = 1'b1;
        end
        if (mx1 == mn1)
        begin
            north = mx1;
            shared = 1'b1;
        end
        south = (mx0 != north) ? mx0 : mx1;
    end

    logic          ok2_reg;
    logic [DB-1:0] dmax2_reg;
    logic [CB-1:0] nx2_reg, ny2_reg, sx2_reg, sy2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok2_reg   <= shared && !miss1_reg;
            dmax2_reg <= dmx;
            nx2_reg   <= x1_reg[north];
            ny2_reg   <= y1_reg[north];
            sx2_reg   <= x1_reg[south];
            sy2_reg   <= y1_reg[south];
        end
    end

    // stage 2: prepare vectoring
    logic signed [CB:0] vx, vy;
    logic signed [VW-1:0] px, py;
    logic signed [ANG_BITS-1:0] pz;
    always_comb
    begin
        vx = $signed({1'b0, nx2_reg}) - $signed({1'b0, sx2_reg});
        vy = $signed({1'b0, ny2_reg}) - $signed({1'b0, sy2_reg});
        pz = '0;
        if (vx < 0)
        begin
            pz = (vy >= 0) ? PI_Q16 : -PI_Q16;
            vx = -vx;
            vy = -vy;
        end
        px = VW'(vx) <<< 8;
        py = VW'(vy) <<< 8;
    end

    // carried payload through the pipe
    typedef struct packed {
        logic          ok;
        logic          zero;
        logic [CB-1:0] nx;
        logic [CB-1:0] ny;
    } carry_t;

    carry_t cv_reg [S_MUL-1];
    logic signed [VW-1:0] vxr_reg [VSTG+1];
    logic signed [VW-1:0] vyr_reg [VSTG+1];
    logic signed [ANG_BITS-1:0] vzr_reg [VSTG+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cv_reg[0] <= '{ok: ok2_reg, zero: (vx == 0) && (vy == 0),
                           nx: nx2_reg, ny: ny2_reg};
            vxr_reg[0] <= px;
            vyr_reg[0] <= py;
            vzr_reg[0] <= pz;
            for (int k = 1; k <= S_MUL-2; k++) cv_reg[k] <= cv_reg[k-1];
        end
    end

    for (genvar k = 0; k < VSTG; k++)
    begin : g_vec
        logic signed [VW-1:0] xa, ya, xb, yb;
        logic signed [ANG_BITS-1:0] za, zb;
        fscp_cordic_stage #(.W(VW), .STEP(2*k), .VECT(1'b1)) u_a (
            .x_in(vxr_reg[k]), .y_in(vyr_reg[k]), .z_in(vzr_reg[k]),
            .x_out(xa), .y_out(ya), .z_out(za));
        fscp_cordic_stage #(.W(VW), .STEP(2*k+1), .VECT(1'b1)) u_b (
            .x_in(xa), .y_in(ya), .z_in(za),
            .x_out(xb), .y_out(yb), .z_out(zb));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vxr_reg[k+1] <= xb;
                vyr_reg[k+1] <= yb;
                vzr_reg[k+1] <= zb;
            end
        end
    end

    // phi and rotation prep
    logic signed [ANG_BITS-1:0] phi;
    assign phi = cv_reg[VSTG].zero ? '0 : vzr_reg[VSTG];

    logic signed [ANG_BITS-1:0] ra;
    logic                       rneg;
    always_comb
    begin
        ra = phi; rneg = 1'b0;
        if (phi > HALF_PI_Q16)
        begin
            ra = phi - PI_Q16;
            rneg = 1'b1;
        end
        else if (phi < -HALF_PI_Q16)
        begin
            ra = phi + PI_Q16;
            rneg = 1'b1;
        end
    end

    logic signed [RW-1:0] rx_reg [VSTG+1];
    logic signed [RW-1:0] ry_reg [VSTG+1];
    logic signed [ANG_BITS-1:0] rz_reg [VSTG+1];
    logic signed [ANG_BITS-1:0] ph_reg [VSTG+1];
    logic [VSTG:0] neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0] <= RW'(GAIN_Q14);
            ry_reg[0] <= '0;
            rz_reg[0] <= ra;
            ph_reg[0] <= phi;
            neg_reg[0] <= rneg;
            for (int k = 1; k <= VSTG; k++)
            begin
                ph_reg[k]  <= ph_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < VSTG; k++)
    begin : g_rot
        logic signed [RW-1:0] xa, ya, xb, yb;
        logic signed [ANG_BITS-1:0] za, zb;
        fscp_cordic_stage #(.W(RW), .STEP(2*k), .VECT(1'b0)) u_a (
            .x_in(rx_reg[k]), .y_in(ry_reg[k]), .z_in(rz_reg[k]),
            .x_out(xa), .y_out(ya), .z_out(za));
        fscp_cordic_stage #(.W(RW), .STEP(2*k+1), .VECT(1'b0)) u_b (
            .x_in(xa), .y_in(ya), .z_in(za),
            .x_out(xb), .y_out(yb), .z_out(zb));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rx_reg[k+1] <= xb;
                ry_reg[k+1] <= yb;
                rz_reg[k+1] <= zb;
            end
        end
    end

    // square root of 64*dmax, spread over the pipe from stage 2
    logic [SQ_IN-1:0] sq_v_reg [SQ_N+1];
    logic [SQ_W-1:0]  sq_r_reg [SQ_N+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0] <= {dmax2_reg, 6'b0};
            sq_r_reg[0] <= '0;
        end
    end
    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        logic [SQ_IN-1:0] v;
        logic [SQ_W-1:0]  r;
        logic [SQ_IN+1:0] rem, trial;
        always_comb
        begin
            // digit-by-digit restoring root, SQ_PER bits per stage
            v = sq_v_reg[k];
            r = sq_r_reg[k];
            rem = '0;
            trial = '0;
            for (int j = 0; j < SQ_PER; j++)
            begin
                if (k*SQ_PER + j < SQ_STEPS)
                begin
                    trial = (SQ_IN+2)'({r, 2'b01}) << (2*(SQ_STEPS-1-(k*SQ_PER+j)));
                    rem = (SQ_IN+2)'(v);
                    if (rem >= trial)
                    begin
                        v = SQ_IN'(rem - trial);
                        r = {r[SQ_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r = {r[SQ_W-2:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[k+1] <= v;
                sq_r_reg[k+1] <= r;
            end
        end
    end

    // stage S_MUL-1: cos/sin resolved, products
    logic signed [RW-1:0] cp, sp;
    assign cp = neg_reg[VSTG] ? -rx_reg[VSTG] : rx_reg[VSTG];
    assign sp = neg_reg[VSTG] ? -ry_reg[VSTG] : ry_reg[VSTG];

    logic signed [UW-1:0] ux, uy;
    assign ux = $signed(UW'(cx_reg)) - $signed(UW'({cv_reg[S_MUL-3].nx, 4'b0}));
    assign uy = $signed(UW'(cy_reg)) - $signed(UW'({cv_reg[S_MUL-3].ny, 4'b0}));

    logic signed [47:0] m_su_reg, m_cu_reg, m_cv_reg, m_sv_reg;
    logic [SQ_W-1:0]    root_reg;
    logic signed [ANG_BITS-1:0] phm_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_su_reg <= 48'(sp) * 48'(ux);
            m_cu_reg <= 48'(cp) * 48'(ux);
            m_cv_reg <= 48'(cp) * 48'(uy);
            m_sv_reg <= 48'(sp) * 48'(uy);
            root_reg <= sq_r_reg[SQ_N];
            phm_reg  <= ph_reg[VSTG];
        end
    end

    // sums
    logic signed [47:0] r0, r1, hd;
    assign r0 = WORLD_X_Q4 + ((m_su_reg - m_cv_reg + 48'sd8192) >>> 14);
    assign r1 = WORLD_Y_Q4 + $signed(48'(root_reg))
                + ((m_cu_reg + m_sv_reg + 48'sd8192) >>> 14);
    assign hd = (48'(HALF_PI_Q16) + 48'(phm_reg) + 48'sd8) >>> 4;

    logic signed [POS_BITS-1:0] px_reg, py_reg;
    logic signed [HEAD_BITS-1:0] hd_reg;
    logic ok_s_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg   <= POS_BITS'(clamp48(MIRROR_Q4 - r0, POS_MIN, POS_MAX));
            py_reg   <= POS_BITS'(clamp48(r1, POS_MIN, POS_MAX));
            hd_reg   <= HEAD_BITS'(clamp48(hd, HEAD_MIN, HEAD_MAX));
            ok_s_reg <= cv_reg[S_MUL-2].ok;
        end
    end

    // output register
    logic                        found_reg;
    logic signed [POS_BITS-1:0]  ox_reg, oy_reg;
    logic signed [HEAD_BITS-1:0] oh_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= ok_s_reg;
            ox_reg    <= ok_s_reg ? px_reg : '0;
            oy_reg    <= ok_s_reg ? py_reg : '0;
            oh_reg    <= ok_s_reg ? hd_reg : '0;
        end
    end

    assign found   = found_reg;
    assign pos_x   = ox_reg;
    assign pos_y   = oy_reg;
    assign heading = oh_reg;
endmodule

// ===== hw/rtl/fscp_dist_lane.sv =====
// ----------------------------------------------------------------------------
// fscp_dist_lane: one pair-distance lane
// Forms the squared distance between two blobs, registered.
// ----------------------------------------------------------------------------
module fscp_dist_lane #(
    parameter int COORD_BITS = fscp_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [COORD_BITS-1:0]     ax,
    input  logic [COORD_BITS-1:0]     ay,
    input  logic [COORD_BITS-1:0]     bx,
    input  logic [COORD_BITS-1:0]     by,
    output logic [2*COORD_BITS+1:0]   dsq
);
    import fscp_pkg::*;

    logic signed [COORD_BITS:0]     dx;
    logic signed [COORD_BITS:0]     dy;
    logic signed [2*COORD_BITS+1:0] dxw;
    logic signed [2*COORD_BITS+1:0] dyw;
    logic [2*COORD_BITS+1:0]        dist_reg;
    logic [2*COORD_BITS+1:0]        dist_next;

    always_comb
    begin
        dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
        dy = $signed({1'b0, by}) - $signed({1'b0, ay});
        // widen before squaring so the products keep every bit
        dxw = (2*COORD_BITS+2)'(dx);
        dyw = (2*COORD_BITS+2)'(dy);
        dist_next = unsigned'(dxw * dxw) + unsigned'(dyw * dyw);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign dsq = dist_reg;
endmodule

// ===== hw/rtl/fscp_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// fscp_cordic_stage: one CORDIC micro-rotation
// Vectoring step (drive y toward zero) or rotation step (drive angle to zero).
// ----------------------------------------------------------------------------
module fscp_cordic_stage #(
    parameter int W     = 32,
    parameter int STEP  = 0,
    parameter bit VECT  = 1'b1
) (
    input  logic signed [W-1:0]                  x_in,
    input  logic signed [W-1:0]                  y_in,
    input  logic signed [fscp_pkg::ANG_BITS-1:0] z_in,
    output logic signed [W-1:0]                  x_out,
    output logic signed [W-1:0]                  y_out,
    output logic signed [fscp_pkg::ANG_BITS-1:0] z_out
);
    import fscp_pkg::*;

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic                up;

    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        // vectoring rotates clockwise while y is positive
        up = VECT ? (y_in > 0) : (z_in < 0);
        if (VECT ? up : !up)
        begin
            x_out = VECT ? x_in + ys : x_in - ys;
            y_out = VECT ? y_in - xs : y_in + xs;
            z_out = VECT ? z_in + atan_q16(STEP) : z_in - atan_q16(STEP);
        end
        else
        begin
            x_out = VECT ? x_in - ys : x_in + ys;
            y_out = VECT ? y_in + xs : y_in - xs;
            z_out = VECT ? z_in - atan_q16(STEP) : z_in + atan_q16(STEP);
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Four-star pose testbench
// Drives blob constellations through the valid/stall input channel, predicts
// found, position and heading with a fixed-point pose predictor, and checks
// each output transaction in order. Center registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fscp_pkg::*;

    localparam int CB        = 10;
    localparam int IDLE_WAIT = 200;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        logic [CB-1:0] x [4];
        logic [CB-1:0] y [4];
    } constellation_t;

    typedef struct {
        logic                        fnd;
        logic signed [POS_BITS-1:0]  px;
        logic signed [POS_BITS-1:0]  py;
        logic signed [HEAD_BITS-1:0] hd;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [CB-1:0] star0_x = '0, star0_y = '0, star1_x = '0, star1_y = '0;
    logic [CB-1:0] star2_x = '0, star2_y = '0, star3_x = '0, star3_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic found;
    logic signed [POS_BITS-1:0] pos_x, pos_y;
    logic signed [HEAD_BITS-1:0] heading;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    logic [CFG_BITS-1:0] ctr_x = 14'd8184;
    logic [CFG_BITS-1:0] ctr_y = 14'd6136;

    pose_t pose_q[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    in_gaps = 1'b1;
    bit    out_gaps = 1'b1;
    bit    hold_output = 1'b0;
    int    hold_len = 0;

    always #5 clk = ~clk;

    four_star_constellation_pose_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .star0_x(star0_x), .star0_y(star0_y), .star1_x(star1_x), .star1_y(star1_y),
        .star2_x(star2_x), .star2_y(star2_y), .star3_x(star3_x), .star3_y(star3_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sqrt_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
            begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint vy, longint vx);
        longint z, xs, ys;
        z = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0)
        begin
            z = (vy >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
            vx = -vx;
            vy = -vy;
        end
        vx = vx * 256;
        vy = vy * 256;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = fshift(vx, i);
            ys = fshift(vy, i);
            if (vy > 0)
            begin
                vx += ys; vy -= xs; z += longint'(atan_q16(i));
            end
            else
            begin
                vx -= ys; vy += xs; z -= longint'(atan_q16(i));
            end
        end
        return z;
    endfunction

    function automatic void rotate_unit(input longint a, output longint c,
                                        output longint s);
        longint vx, vy, xs, ys;
        bit neg;
        vx = longint'(GAIN_Q14);
        vy = 0;
        neg = 1'b0;
        if (a > longint'(HALF_PI_Q16))
        begin
            a -= longint'(PI_Q16); neg = 1'b1;
        end
        else if (a < -longint'(HALF_PI_Q16))
        begin
            a += longint'(PI_Q16); neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = fshift(vx, i);
            ys = fshift(vy, i);
            if (a >= 0)
            begin
                vx -= ys; vy += xs; a -= longint'(atan_q16(i));
            end
            else
            begin
                vx += ys; vy -= xs; a += longint'(atan_q16(i));
            end
        end
        c = neg ? -vx : vx;
        s = neg ? -vy : vy;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic pose_t predict_pose(constellation_t k);
        pose_t  p;
        longint x [4], y [4], d [6];
        longint dmax, dmin, phi, cp, sp, ux, uy, r0, r1, hd, dx, dy;
        int     imax, imin, north, south;
        bit     shared;
        int     mx [2], mn [2];
        p = '{1'b0, '0, '0, '0};
        imax = 0; imin = 0; north = 0; shared = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            x[i] = k.x[i];
            y[i] = k.y[i];
            if (k.y[i] == '1) return p;
        end
        for (int i = 0; i < 6; i++)
        begin
            dx = x[pair_b(3'(i))] - x[pair_a(3'(i))];
            dy = y[pair_b(3'(i))] - y[pair_a(3'(i))];
            d[i] = dx * dx + dy * dy;
        end
        dmax = d[0]; dmin = d[0];
        for (int i = 0; i < 6; i++)
        begin
            if (d[i] >= dmax)
            begin
                dmax = d[i]; imax = i;
            end
            if (d[i] <= dmin)
            begin
                dmin = d[i]; imin = i;
            end
        end
        mx[0] = pair_a(3'(imax)); mx[1] = pair_b(3'(imax));
        mn[0] = pair_a(3'(imin)); mn[1] = pair_b(3'(imin));
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                if (mx[i] == mn[j])
                begin
                    north = mx[i]; shared = 1'b1;
                end
        if (!shared) return p;
        south = (mx[0] != north) ? mx[0] : mx[1];
        phi = vector_angle(y[north] - y[south], x[north] - x[south]);
        hd = fshift(longint'(HALF_PI_Q16) + phi + 8, 4);
        rotate_unit(phi, cp, sp);
        ux = longint'(ctr_x) - x[north] * 16;
        uy = longint'(ctr_y) - y[north] * 16;
        r0 = 8184 + fshift(sp * ux - cp * uy + 8192, 14);
        r1 = 6136 + sqrt_floor(dmax * 64) + fshift(cp * ux + sp * uy + 8192, 14);
        p.fnd = 1'b1;
        p.px = POS_BITS'(sat(16352 - r0, -65536, 65535));
        p.py = POS_BITS'(sat(r1, -65536, 65535));
        p.hd = HEAD_BITS'(sat(hd, -6434, 19302));
        return p;
    endfunction

    // Input channel: one transaction per call, optional random gap first.
    task automatic send_stars(constellation_t k);
        if (in_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        star0_x <= k.x[0]; star0_y <= k.y[0]; star1_x <= k.x[1]; star1_y <= k.y[1];
        star2_x <= k.x[2]; star2_y <= k.y[2]; star3_x <= k.x[3]; star3_y <= k.y[3];
        in_valid <= 1'b1;
        pose_q.push_back(predict_pose(k));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_center(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_CENTER_X) ctr_x = val;
        else ctr_y = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pose_q.size() != 0) @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    function automatic constellation_t rand_stars(int mode);
        constellation_t k;
        int cx, cy, r;
        cx = $urandom_range(100, 900);
        cy = $urandom_range(100, 900);
        r = $urandom_range(4, 90);
        for (int i = 0; i < 4; i++)
        begin
            if (mode == 0)
            begin
                k.x[i] = CB'($urandom);
                k.y[i] = CB'($urandom_range(0, 1022));
            end
            else
            begin
                k.x[i] = CB'(cx + int'($urandom_range(0, 2 * r)) - r);
                k.y[i] = CB'(cy + int'($urandom_range(0, 2 * r)) - r);
            end
        end
        if ($urandom_range(0, 15) == 0) k.y[$urandom_range(0, 3)] = '1;
        return k;
    endfunction

    function automatic constellation_t make_stars(int a, int b, int c, int d, int e,
                                                  int f, int g, int h);
        constellation_t k;
        k.x[0] = CB'(a); k.y[0] = CB'(b); k.x[1] = CB'(c); k.y[1] = CB'(d);
        k.x[2] = CB'(e); k.y[2] = CB'(f); k.x[3] = CB'(g); k.y[3] = CB'(h);
        return k;
    endfunction

    task automatic test_directed;
        send_stars(make_stars(0, 0, 0, 0, 0, 0, 0, 0));
        send_stars(make_stars(1023, 1022, 1023, 1022, 1023, 1022, 1023, 1022));
        send_stars(make_stars(10, 10, 10, 1023, 20, 20, 30, 30));
        send_stars(make_stars(10, 1023, 10, 10, 20, 20, 30, 30));
        send_stars(make_stars(5, 5, 6, 6, 7, 7, 1023, 1023));
        // triangle-plus-point where largest and smallest share a star
        send_stars(make_stars(500, 300, 500, 320, 560, 400, 470, 390));
        // two smallest pairs tie; the later one shares a star with the largest
        send_stars(make_stars(0, 0, 1, 0, 1000, 1000, 1000, 1001));
        // square: four sides tie and both diagonals tie; the later pair wins each tie
        send_stars(make_stars(100, 100, 200, 100, 100, 200, 200, 200));
        send_stars(make_stars(0, 0, 1023, 1022, 0, 1022, 1023, 0));
        send_stars(make_stars(1023, 0, 0, 1022, 1022, 1, 1, 1021));
        send_stars(make_stars(512, 384, 512, 400, 530, 384, 480, 360));
        send_stars(make_stars(512, 384, 500, 384, 512, 420, 560, 384));
        send_stars(make_stars(341, 682, 682, 341, 341, 340, 682, 681));
        send_stars(make_stars(3, 700, 900, 2, 4, 700, 600, 600));
        drain();
    endtask

    task automatic test_random(int n, int noise_pct);
        for (int i = 0; i < n; i++)
            send_stars(rand_stars($urandom_range(0, 99) < noise_pct ? 0 : 1));
    endtask

    task automatic test_config_sweep;
        logic [CFG_BITS-1:0] vals [4] = '{14'd0, 14'd16383, 14'd8184, 14'd0};
        for (int i = 0; i < 4; i++)
        begin
            write_center(CFG_CENTER_X, vals[i]);
            write_center(CFG_CENTER_Y, vals[3 - i]);
            test_random(150, 25);
            drain();
        end
        write_center(CFG_CENTER_X, CFG_BITS'($urandom));
        write_center(CFG_CENTER_Y, CFG_BITS'($urandom));
        test_random(150, 25);
        drain();
    endtask

    task automatic test_backpressure;
        hold_len = 300;
        hold_output = 1'b1;
        test_random(80, 20);
        drain();
        test_random(60, 20);
        // sender waits for everything to come back
        drain();
        test_random(60, 20);
        drain();
    endtask

    task automatic test_full_rate;
        in_gaps = 1'b0;
        out_gaps = 1'b0;
        write_center(CFG_CENTER_X, 14'd8184);
        write_center(CFG_CENTER_Y, 14'd6136);
        test_random(480, 10);
        drain();
    endtask

    // Output side: random stall bursts plus the long hold.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(negedge clk);
                hold_output = 1'b0;
                out_stall <= 1'b0;
            end
            else if (out_gaps && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output transaction");
            end
            else
            begin
                e = pose_q.pop_front();
                if (found !== e.fnd || pos_x !== e.px || pos_y !== e.py
                    || heading !== e.hd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %b %0d %0d %0d got %b %0d %0d %0d",
                                 e.fnd, e.px, e.py, e.hd, found, pos_x, pos_y, heading);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("four_star_constellation_pose_top test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(200, 30);
        drain();
        test_config_sweep();
        test_backpressure();
        test_full_rate();
        if (mismatches == 0 && pose_q.size() == 0)
            $display("four_star_constellation_pose_top test passed");
        else
            $display("four_star_constellation_pose_top test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/fscp_pkg.sv
hw/rtl/fscp_dist_lane.sv
hw/rtl/fscp_cordic_stage.sv
hw/rtl/four_star_constellation_pose_top.sv
bench/tb_top.sv
